// ===== rtl/ssfd_pkg.sv =====
// Shared constants, register codes and inter-module types for the stereo
// slewed fractional delay unit. No dependencies.
`default_nettype none
package ssfd_pkg;

	localparam int RING_DEPTH_DEF  = 262144;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int DELAY_W    = 18;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 18;
	localparam int PPM_W      = 7;
	localparam int MILLI_W    = 10;
	localparam int RAMP_W     = 18;

	localparam int SLEW_MAX      = 4;
	localparam int RATE_LIMIT    = 50;
	localparam int PHASE_PER_PPM = 4295;
	localparam int PINC_W        = 19;
	localparam int PHASE_FRAC_W  = 32;
	localparam int FRAC_W        = 16;

	localparam int MILLI_FULL = 1000;
	localparam int GAIN_FRAC  = 24;
	localparam int GAIN_W     = GAIN_FRAC + 1;
	localparam int GAIN_ONE   = 1 << GAIN_FRAC;

	localparam int DIV_NUM_W = MILLI_W + GAIN_FRAC;
	localparam int DIV_DEN_W = RAMP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_DELAY = 4'd0,
		REG_RATE_PPM     = 4'd1,
		REG_TARGET_GAIN  = 4'd2,
		REG_GAIN_RAMP    = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic              ok0;
		logic              ok1;
		logic              ld_y;
		logic [FRAC_W-1:0] frac;
		logic [GAIN_W-1:0] gain;
	} lane_ctl_t;

	typedef struct packed {
		logic in_ready;
		logic cfg_ready;
		logic valid_s3;
	} ctl_stat_t;

endpackage
`default_nettype wire

// ===== rtl/ssfd_ifs.sv =====
// Channel interfaces of the delay unit: input frames, results and register writes.
// Depends on ssfd_pkg.
`default_nettype none
interface ssfd_frame_if #(parameter int SAMPLE_BITS = ssfd_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;
	modport source(output valid, sample_left, sample_right, input ready);
	modport sink(input valid, sample_left, sample_right, output ready);
endinterface

interface ssfd_result_if #(parameter int SAMPLE_BITS = ssfd_pkg::SAMPLE_BITS_DEF);
	import ssfd_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic [DELAY_W-1:0]            delay_now;
	modport source(output valid, out_left, out_right, delay_now, input ready);
	modport sink(input valid, out_left, out_right, delay_now, output ready);
endinterface

interface ssfd_cfg_if;
	import ssfd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssfd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ssfd_pkg.
`default_nettype none
module ssfd_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [ssfd_pkg::DIV_NUM_W-1:0]  num,
	input  wire logic [ssfd_pkg::DIV_DEN_W-1:0]  den,
	output logic                                 busy,
	output logic                                 done,
	output logic [ssfd_pkg::DIV_NUM_W-1:0]       quot
);
	import ssfd_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] n_q;
	logic [DIV_DEN_W-1:0] d_q;
	logic [DIV_DEN_W-1:0] r_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 sub_ok;

	assign trial  = {r_q, n_q[DIV_NUM_W-1]};
	assign sub_ok = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= sub_ok ? DIV_DEN_W'(trial - {1'b0, d_q}) : trial[DIV_DEN_W-1:0];
			n_q <= {n_q[DIV_NUM_W-2:0], sub_ok};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = n_q;
endmodule
`default_nettype wire

// ===== rtl/ssfd_ctrl.sv =====
// Frame sequencer: register file, delay slew, phase accumulator, gain ramp,
// write position and read position for both lanes. Depends on ssfd_pkg, ssfd_div.
`default_nettype none
module ssfd_ctrl #(
	parameter int RING_DEPTH = ssfd_pkg::RING_DEPTH_DEF,
	parameter int RING_AW    = $clog2(RING_DEPTH)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [ssfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ssfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	input  wire logic                             take_s3,
	output ssfd_pkg::ctl_stat_t                   stat,
	output ssfd_pkg::lane_ctl_t                   lane_ctl,
	output logic [RING_AW-1:0]                    wr_addr,
	output logic [RING_AW-1:0]                    rd_addr0,
	output logic [RING_AW-1:0]                    rd_addr1,
	output logic [ssfd_pkg::DELAY_W-1:0]          delay_now
);
	import ssfd_pkg::*;

	localparam int PH_W = RING_AW + PHASE_FRAC_W;
	localparam logic [DELAY_W-1:0] DELAY_MAX =
		(RING_AW >= DELAY_W) ? {DELAY_W{1'b1}} : DELAY_W'(RING_DEPTH - 1);
	localparam logic signed [PPM_W-1:0] PPM_HI = PPM_W'(RATE_LIMIT);
	localparam logic signed [PPM_W-1:0] PPM_LO = -PPM_HI;

	typedef enum logic {DST_GAIN, DST_STEP} div_dst_t;

	logic [DELAY_W-1:0]       tdelay_q;
	logic signed [PINC_W-1:0] pinc_q;
	logic [GAIN_W-1:0]        tgain_q;
	logic [GAIN_W-1:0]        step_q;
	logic                     ramp_zero_q;
	div_dst_t                 div_dst_q;
	logic [DELAY_W-1:0]       delay_q;
	logic [PH_W-1:0]          phase_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [RING_AW-1:0]       wp_q;
	logic                     wrapped_q;
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     valid_s3;
	logic [FRAC_W-1:0]        frac_s2;

	logic                     div_start;
	logic                     div_busy;
	logic                     div_done;
	logic [DIV_NUM_W-1:0]     div_num;
	logic [DIV_DEN_W-1:0]     div_den;
	logic [DIV_NUM_W-1:0]     div_quot;

	logic                     cfg_acc;
	logic                     in_acc;
	logic signed [PPM_W-1:0]  ppm_raw;
	logic signed [PPM_W-1:0]  ppm_c;
	logic signed [PINC_W-1:0] pinc_nx;
	logic [MILLI_W-1:0]       milli_c;
	logic [RAMP_W-1:0]        ramp;
	logic [DELAY_W-1:0]       tgt_c;
	logic [DELAY_W-1:0]       delay_nx;
	logic [GAIN_W-1:0]        gain_nx;
	logic [RING_AW-1:0]       wd;
	logic [PH_W-1:0]          pos;
	logic [RING_AW-1:0]       i0;
	logic [RING_AW-1:0]       i1;

	assign stat.cfg_ready = !(div_busy || div_done);
	assign stat.in_ready  = !(div_busy || div_done) && !valid_s1 && !valid_s2 && !valid_s3;
	assign stat.valid_s3  = valid_s3;
	assign cfg_acc = cfg_valid && stat.cfg_ready;
	assign in_acc  = in_valid && stat.in_ready;

	assign ppm_raw = $signed(cfg_data[PPM_W-1:0]);
	assign ppm_c   = (ppm_raw > PPM_HI) ? PPM_HI : ((ppm_raw < PPM_LO) ? PPM_LO : ppm_raw);
	assign pinc_nx = PINC_W'(ppm_c) * PINC_W'(PHASE_PER_PPM);
	assign milli_c = (cfg_data[MILLI_W-1:0] > MILLI_W'(MILLI_FULL)) ?
		MILLI_W'(MILLI_FULL) : cfg_data[MILLI_W-1:0];
	assign ramp    = cfg_data[RAMP_W-1:0];

	assign div_start = cfg_acc && ((cfg_index == REG_TARGET_GAIN) ||
		((cfg_index == REG_GAIN_RAMP) && (ramp != '0)));

	always_comb begin
		if (cfg_index == REG_TARGET_GAIN) begin
			div_num = DIV_NUM_W'({milli_c, {GAIN_FRAC{1'b0}}}) + DIV_NUM_W'(MILLI_FULL / 2);
			div_den = DIV_DEN_W'(MILLI_FULL);
		end else begin
			div_num = DIV_NUM_W'(GAIN_ONE);
			div_den = ramp;
		end
	end

	ssfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign tgt_c = (tdelay_q > DELAY_MAX) ? DELAY_MAX : tdelay_q;

	always_comb begin
		if (tgt_c > delay_q) begin
			delay_nx = ((tgt_c - delay_q) > DELAY_W'(SLEW_MAX)) ?
				delay_q + DELAY_W'(SLEW_MAX) : tgt_c;
		end else if (tgt_c < delay_q) begin
			delay_nx = ((delay_q - tgt_c) > DELAY_W'(SLEW_MAX)) ?
				delay_q - DELAY_W'(SLEW_MAX) : tgt_c;
		end else begin
			delay_nx = delay_q;
		end
	end

	always_comb begin
		if (ramp_zero_q) begin
			gain_nx = tgain_q;
		end else if (tgain_q > gain_q) begin
			gain_nx = (step_q >= (tgain_q - gain_q)) ? tgain_q : gain_q + step_q;
		end else if (tgain_q < gain_q) begin
			gain_nx = (step_q >= (gain_q - tgain_q)) ? tgain_q : gain_q - step_q;
		end else begin
			gain_nx = gain_q;
		end
	end

	// Read position is write position minus delay minus phase, modulo the ring.
	assign wd  = wp_q - RING_AW'(delay_q);
	assign pos = {wd, {PHASE_FRAC_W{1'b0}}} - phase_q;
	assign i0  = pos[PH_W-1:PHASE_FRAC_W];
	assign i1  = i0 + RING_AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tdelay_q    <= '0;
			pinc_q      <= '0;
			tgain_q     <= GAIN_W'(GAIN_ONE);
			step_q      <= '0;
			ramp_zero_q <= 1'b1;
			div_dst_q   <= DST_GAIN;
			delay_q     <= '0;
			phase_q     <= '0;
			gain_q      <= GAIN_W'(GAIN_ONE);
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_TARGET_DELAY: tdelay_q <= cfg_data[DELAY_W-1:0];
					REG_RATE_PPM:     pinc_q   <= pinc_nx;
					REG_TARGET_GAIN:  div_dst_q <= DST_GAIN;
					REG_GAIN_RAMP: begin
						ramp_zero_q <= (ramp == '0);
						div_dst_q   <= DST_STEP;
					end
					default: ;
				endcase
			end
			if (div_done) begin
				if (div_dst_q == DST_GAIN) begin
					tgain_q <= div_quot[GAIN_W-1:0];
				end else begin
					step_q <= div_quot[GAIN_W-1:0];
				end
			end
			valid_s1 <= in_acc;
			if (in_acc) begin
				delay_q <= delay_nx;
				phase_q <= phase_q + PH_W'(pinc_q);
				gain_q  <= gain_nx;
			end
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				wp_q <= wp_q + RING_AW'(1);
				if (wp_q == {RING_AW{1'b1}}) begin
					wrapped_q <= 1'b1;
				end
			end
			if (valid_s2) begin
				valid_s3 <= 1'b1;
			end else if (take_s3) begin
				valid_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			frac_s2 <= pos[PHASE_FRAC_W-1:PHASE_FRAC_W-FRAC_W];
		end
	end

	// An entry never written since reset lies above the write position until the first wrap.
	assign lane_ctl.wr_en = in_acc;
	assign lane_ctl.rd_en = valid_s1;
	assign lane_ctl.ok0   = wrapped_q || (i0 <= wp_q);
	assign lane_ctl.ok1   = wrapped_q || (i1 <= wp_q);
	assign lane_ctl.ld_y  = valid_s2;
	assign lane_ctl.frac  = frac_s2;
	assign lane_ctl.gain  = gain_q;

	assign wr_addr   = wp_q;
	assign rd_addr0  = i0;
	assign rd_addr1  = i1;
	assign delay_now = delay_q;
endmodule
`default_nettype wire

// ===== rtl/ssfd_lane.sv =====
// One audio channel: ring memory, linear interpolation and gain scaling.
// Depends on ssfd_pkg; driven by ssfd_ctrl.
`default_nettype none
module ssfd_lane #(
	parameter int RING_DEPTH  = ssfd_pkg::RING_DEPTH_DEF,
	parameter int RING_AW     = $clog2(RING_DEPTH),
	parameter int SAMPLE_BITS = ssfd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire ssfd_pkg::lane_ctl_t           ctl,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic [RING_AW-1:0]            wr_addr,
	input  wire logic [RING_AW-1:0]            rd_addr0,
	input  wire logic [RING_AW-1:0]            rd_addr1,
	output logic signed [SAMPLE_BITS-1:0]      scaled
);
	import ssfd_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int ACC_W = SB + FRAC_W + 2;
	localparam int PRD_W = SB + GAIN_W + 1;
	localparam int RES_W = PRD_W - GAIN_FRAC;
	localparam logic signed [RES_W-1:0] MAXV = RES_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [RES_W-1:0] MINV = -MAXV - RES_W'(1);

	logic signed [SB-1:0]    mem_q [RING_DEPTH];
	logic signed [SB-1:0]    rd0_s2;
	logic signed [SB-1:0]    rd1_s2;
	logic                    ok0_s2;
	logic                    ok1_s2;
	logic signed [SB-1:0]    y_s3;
	logic signed [SB-1:0]    e0;
	logic signed [SB-1:0]    e1;
	logic signed [SB:0]      dif;
	logic signed [ACC_W-1:0] lprod;
	logic signed [ACC_W-1:0] acc;
	logic signed [PRD_W-1:0] gprod;
	logic signed [PRD_W-1:0] gsum;
	logic signed [RES_W-1:0] res;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= sample;
		end
		if (ctl.rd_en) begin
			rd0_s2 <= mem_q[rd_addr0];
			rd1_s2 <= mem_q[rd_addr1];
			ok0_s2 <= ctl.ok0;
			ok1_s2 <= ctl.ok1;
		end
	end

	assign e0    = ok0_s2 ? rd0_s2 : '0;
	assign e1    = ok1_s2 ? rd1_s2 : '0;
	assign dif   = {e1[SB-1], e1} - {e0[SB-1], e0};
	assign lprod = dif * $signed({1'b0, ctl.frac});
	assign acc   = {{2{e0[SB-1]}}, e0, {FRAC_W{1'b0}}} + lprod + ACC_W'(1 << (FRAC_W - 1));

	always_ff @(posedge clk) begin
		if (ctl.ld_y) begin
			y_s3 <= acc[SB+FRAC_W-1:FRAC_W];
		end
	end

	assign gprod = y_s3 * $signed({1'b0, ctl.gain});
	assign gsum  = gprod + PRD_W'(GAIN_ONE / 2);
	assign res   = gsum[PRD_W-1:GAIN_FRAC];

	always_comb begin
		if (res > MAXV) begin
			scaled = MAXV[SB-1:0];
		end else if (res < MINV) begin
			scaled = MINV[SB-1:0];
		end else begin
			scaled = res[SB-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/stereo_slewed_fractional_delay_unit.sv =====
// Top level of the stereo slewed fractional delay unit: sequencer, two lanes
// and the output register. Depends on ssfd_pkg, ssfd_ifs, ssfd_ctrl, ssfd_lane.
//
// Usage: each request on frames carries one stereo frame. Both samples are
// written into two ring memories at a shared write position, read back by
// linear interpolation at the slewed delay and phase, scaled by the ramped
// gain, and returned as one request on results together with the delay used.
// The sequencer walks one frame at a time through memory write, memory read,
// interpolation and scaling, and takes a new frame only once the last one has
// moved from its scaling stage into the output register.
// Register writes on cfg are to come while no frame is in flight; the block
// itself does not enforce this. Writing the target gain, or a nonzero ramp
// length, runs the shared serial divider, during which cfg and frames are held off.
// After reset the rings read as zero: entries above the write position count as
// unwritten until the position first wraps, so no clearing pass is needed.
// RING_DEPTH must be a power of two.
// When results is stalled, the result holds in the output register while the
// next frame is accepted and carried up to its scaling stage.
`default_nettype none
module stereo_slewed_fractional_delay_unit #(
	parameter int RING_DEPTH  = ssfd_pkg::RING_DEPTH_DEF,
	parameter int SAMPLE_BITS = ssfd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ssfd_frame_if.sink     frames,
	ssfd_result_if.source  results,
	ssfd_cfg_if.sink       cfg
);
	import ssfd_pkg::*;

	localparam int RING_AW = $clog2(RING_DEPTH);

	ctl_stat_t                   stat;
	lane_ctl_t                   lane_ctl;
	logic [RING_AW-1:0]          wr_addr;
	logic [RING_AW-1:0]          rd_addr0;
	logic [RING_AW-1:0]          rd_addr1;
	logic [DELAY_W-1:0]          delay_now;
	logic signed [SAMPLE_BITS-1:0] left_scaled;
	logic signed [SAMPLE_BITS-1:0] right_scaled;
	logic                        take_s3;
	logic                        out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_left_q;
	logic signed [SAMPLE_BITS-1:0] out_right_q;
	logic [DELAY_W-1:0]          delay_q;

	ssfd_ctrl #(.RING_DEPTH(RING_DEPTH), .RING_AW(RING_AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.in_valid  (frames.valid),
		.take_s3   (take_s3),
		.stat      (stat),
		.lane_ctl  (lane_ctl),
		.wr_addr   (wr_addr),
		.rd_addr0  (rd_addr0),
		.rd_addr1  (rd_addr1),
		.delay_now (delay_now)
	);

	ssfd_lane #(.RING_DEPTH(RING_DEPTH), .RING_AW(RING_AW), .SAMPLE_BITS(SAMPLE_BITS)) u_left (
		.clk      (clk),
		.ctl      (lane_ctl),
		.sample   (frames.sample_left),
		.wr_addr  (wr_addr),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.scaled   (left_scaled)
	);

	ssfd_lane #(.RING_DEPTH(RING_DEPTH), .RING_AW(RING_AW), .SAMPLE_BITS(SAMPLE_BITS)) u_right (
		.clk      (clk),
		.ctl      (lane_ctl),
		.sample   (frames.sample_right),
		.wr_addr  (wr_addr),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.scaled   (right_scaled)
	);

	assign frames.ready = stat.in_ready;
	assign cfg.ready    = stat.cfg_ready;
	assign take_s3      = stat.valid_s3 && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s3) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3) begin
			out_left_q  <= left_scaled;
			out_right_q <= right_scaled;
			delay_q     <= delay_now;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.out_left  = out_left_q;
	assign results.out_right = out_right_q;
	assign results.delay_now = delay_q;
endmodule
`default_nettype wire

// ===== rtl/ssfd_chk.sv =====
// Port-level checks for the delay unit, attached to the top level by bind.
// Depends on ssfd_pkg and stereo_slewed_fractional_delay_unit.
`default_nettype none
module ssfd_chk #(
	parameter int SAMPLE_BITS = ssfd_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [SAMPLE_BITS-1:0]           out_left,
	input wire logic [SAMPLE_BITS-1:0]           out_right,
	input wire logic [ssfd_pkg::DELAY_W-1:0]     delay_now,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready,
	input wire logic [ssfd_pkg::CFG_IDX_W-1:0]   cfg_index
);
	import ssfd_pkg::*;

	logic [DELAY_W-1:0] last_q;
	logic               seen_q;
	logic [DELAY_W-1:0] ddiff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_q <= '0;
		end else if (out_valid && out_ready) begin
			seen_q <= 1'b1;
			last_q <= delay_now;
		end
	end

	assign ddiff = (delay_now >= last_q) ? delay_now - last_q : last_q - delay_now;

	// Only one frame is in flight at a time.
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("frame accepted while another was in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right)
			&& $stable(delay_now))
		else $error("stalled result changed");

	// Successive results never move the delay by more than the slew limit.
	a_slew: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> ddiff <= DELAY_W'(SLEW_MAX))
		else $error("delay moved faster than the slew limit");

	// A target gain write always occupies the divider.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_TARGET_GAIN) |=> !cfg_ready && !in_ready)
		else $error("target gain write did not hold off the ports");
endmodule

bind stereo_slewed_fractional_delay_unit ssfd_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_ssfd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frames.valid),
	.in_ready  (frames.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_left  (results.out_left),
	.out_right (results.out_right),
	.delay_now (results.delay_now),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.cfg_index (cfg.index)
);
`default_nettype wire
